// ===== sv/lpbd_pkg.sv =====
// Package: shared types and codes of the LRU page-buffer directory.
`default_nettype none

package lpbd_pkg;

  localparam int TAG_W  = 16;
  localparam int SEL_W  = 4;
  localparam int FREE_W = 5;

  localparam logic [TAG_W-1:0]  EMPTY_TAG       = 16'hffff;
  localparam logic [FREE_W-1:0] FREE_NEEDED_RST = 5'd3;

  localparam logic [2:0] MODE_LOAD   = 3'd0;
  localparam logic [2:0] MODE_INIT   = 3'd1;
  localparam logic [2:0] MODE_LOCK   = 3'd2;
  localparam logic [2:0] MODE_UNLOCK = 3'd3;
  localparam logic [2:0] MODE_INVAL  = 3'd4;

  localparam logic [1:0] STAT_HIT  = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;
  localparam logic [1:0] STAT_DONE = 2'd3;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_PROG  = 2'd1;
  localparam logic [1:0] KIND_ERASE = 2'd2;
  localparam logic [1:0] KIND_RELOC = 2'd3;

  typedef struct packed {
    logic [2:0]       mode;
    logic [TAG_W-1:0] page_tag;
    logic [TAG_W-1:0] owner_page;
    logic [SEL_W-1:0] slot_sel;
    logic [1:0]       kind_req;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [SEL_W-1:0] slot_index;
    logic [TAG_W-1:0] slot_owner;
    logic [1:0]       slot_kind;
    logic             slot_locked;
    logic             has_free;
  } out_word_t;

  typedef logic [FREE_W-1:0] cfg_word_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [TAG_W-1:0] owner;
    logic [1:0]       kind;
  } slot_ent_t;

endpackage

`default_nettype wire

// ===== sv/lpbd_if.sv =====
// Interfaces: request, result and configuration channels of the directory.
`default_nettype none

interface lpbd_in_if;
  logic               valid;
  logic               ready;
  lpbd_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lpbd_out_if;
  logic                valid;
  logic                ready;
  lpbd_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lpbd_cfg_if;
  logic                valid;
  logic                ready;
  lpbd_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/lru_page_buffer_directory.sv =====
// Top level: LRU page-buffer directory with per-slot locks, memory based.
//
// Channels: in_ch takes one request word (load, init, lock, unlock,
// invalidate); out_ch returns exactly one result word per request; cfg_ch
// writes free_needed and is always ready. All use valid/ready handshakes.
// Slot tags, owners and kinds live in one memory, the recency order in a
// second one; lock flags and the unlocked-slot count sit in flip-flops.
// Load and init: a scan that reads one slot per cycle from both memories,
// a decide step, then for any hit or a load that fills a slot a
// move-to-front pass that handles one order position per cycle up to the
// slot's position, then a result step.
// Lock, unlock, invalidate: read-modify-write of one entry, then a result step.
// One request is in flight at a time; the next one is taken while the
// previous result still waits in the output register.
// After reset a clearing pass fills every slot of both memories; no
// request is taken during it, configuration writes are.
// A stalled receiver holds the result word; the block finishes its current
// request and then waits before loading the next result.
`default_nettype none

module lru_page_buffer_directory #(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  lpbd_in_if.sink           in_ch,
  lpbd_out_if.source        out_ch,
  lpbd_cfg_if.sink          cfg_ch
);
  import lpbd_pkg::*;

  localparam int SW   = $clog2(SLOTS);
  localparam int RD_W = SW + 1;
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int XW   = (SW + 1 > SEL_W) ? SW + 1 : SEL_W;
  localparam int NW   = (CW > FREE_W) ? CW : FREE_W;
  localparam logic [SW-1:0]   LAST    = SW'(SLOTS - 1);
  localparam logic [RD_W-1:0] RD_END  = RD_W'(SLOTS);
  localparam logic [XW-1:0]   SLOTS_X = XW'(SLOTS);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_DECIDE = 7'b0001000,
    ST_MTF    = 7'b0010000,
    ST_RMW    = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_t;

  // control registers
  state_t            state_r, state_nxt;
  logic [SW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [FREE_W-1:0] free_needed_r, free_needed_nxt;
  logic [RD_W-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic              hit_r, hit_nxt;
  logic              vic_r, vic_nxt;
  logic [RD_W-1:0]   mtf_rd_r, mtf_rd_nxt;
  logic              mtf_dv_r, mtf_dv_nxt;
  logic [SLOTS-1:0]  lock_r, lock_nxt;
  logic [CW-1:0]     free_cnt_r, free_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload registers
  in_word_t          req_r, req_nxt;
  logic              sel_ok_r, sel_ok_nxt;
  logic [SW-1:0]     chk_idx_r, chk_idx_nxt;
  logic [SW-1:0]     hit_slot_r, hit_slot_nxt;
  logic [TAG_W-1:0]  hit_owner_r, hit_owner_nxt;
  logic [1:0]        hit_kind_r, hit_kind_nxt;
  logic [SW-1:0]     vic_slot_r, vic_slot_nxt;
  logic [SW-1:0]     mtf_slot_r, mtf_slot_nxt;
  logic [SW-1:0]     carry_r, carry_nxt;
  logic [SW-1:0]     mtf_wp_r, mtf_wp_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [SEL_W-1:0]  res_idx_r, res_idx_nxt;
  logic [TAG_W-1:0]  res_owner_r, res_owner_nxt;
  logic [1:0]        res_kind_r, res_kind_nxt;
  logic              res_lock_r, res_lock_nxt;
  out_word_t         out_data_r, out_data_nxt;

  // memories
  slot_ent_t         slot_mem [SLOTS];
  logic [SW-1:0]     order_mem [SLOTS];
  slot_ent_t         sm_rdata_r;
  logic [SW-1:0]     om_rdata_r;
  logic              sm_we, sm_re, om_we, om_re;
  logic [SW-1:0]     sm_waddr, sm_raddr, om_waddr, om_raddr;
  slot_ent_t         sm_wdata;
  logic [SW-1:0]     om_wdata;

  logic              lk_we, lk_val;
  logic [SW-1:0]     lk_idx;

  logic [XW-1:0]     in_sel_x, req_sel_x, hit_x, vic_x;
  logic [SW-1:0]     req_sel_a;
  logic              has_free;

  assign in_sel_x  = XW'(in_ch.data.slot_sel);
  assign req_sel_x = XW'(req_r.slot_sel);
  assign req_sel_a = req_sel_x[SW-1:0];
  assign hit_x     = XW'(hit_slot_r);
  assign vic_x     = XW'(vic_slot_r);
  assign has_free  = NW'(free_cnt_r) >= NW'(free_needed_r);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (sm_we) begin
      slot_mem[sm_waddr] <= sm_wdata;
    end
    if (sm_re) begin
      sm_rdata_r <= slot_mem[sm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (om_we) begin
      order_mem[om_waddr] <= om_wdata;
    end
    if (om_re) begin
      om_rdata_r <= order_mem[om_raddr];
    end
  end

  always_comb begin
    slot_ent_t  rmw_ent;
    logic [1:0] rmw_kind;
    logic       rmw_lock;
    logic       rmw_wr;
    logic       is_init;

    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    free_needed_nxt = free_needed_r;
    rd_cnt_nxt      = rd_cnt_r;
    chk_vld_nxt     = 1'b0;
    hit_nxt         = hit_r;
    vic_nxt         = vic_r;
    mtf_rd_nxt      = mtf_rd_r;
    mtf_dv_nxt      = 1'b0;
    lock_nxt        = lock_r;
    free_cnt_nxt    = free_cnt_r;
    out_valid_nxt   = out_valid_r;
    req_nxt         = req_r;
    sel_ok_nxt      = sel_ok_r;
    chk_idx_nxt     = chk_idx_r;
    hit_slot_nxt    = hit_slot_r;
    hit_owner_nxt   = hit_owner_r;
    hit_kind_nxt    = hit_kind_r;
    vic_slot_nxt    = vic_slot_r;
    mtf_slot_nxt    = mtf_slot_r;
    carry_nxt       = carry_r;
    mtf_wp_nxt      = mtf_wp_r;
    res_status_nxt  = res_status_r;
    res_idx_nxt     = res_idx_r;
    res_owner_nxt   = res_owner_r;
    res_kind_nxt    = res_kind_r;
    res_lock_nxt    = res_lock_r;
    out_data_nxt    = out_data_r;

    sm_we    = 1'b0;
    sm_waddr = '0;
    sm_wdata = '{tag: EMPTY_TAG, owner: EMPTY_TAG, kind: KIND_NONE};
    sm_re    = 1'b0;
    sm_raddr = '0;
    om_we    = 1'b0;
    om_waddr = '0;
    om_wdata = '0;
    om_re    = 1'b0;
    om_raddr = '0;
    lk_we    = 1'b0;
    lk_idx   = '0;
    lk_val   = 1'b0;

    rmw_ent  = sm_rdata_r;
    rmw_kind = sm_rdata_r.kind;
    rmw_lock = lock_r[req_sel_a];
    rmw_wr   = 1'b0;
    is_init  = (req_r.mode == MODE_INIT);

    if (cfg_ch.valid) begin
      free_needed_nxt = cfg_ch.data;
    end
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        sm_we       = 1'b1;
        sm_waddr    = clr_cnt_r;
        om_we       = 1'b1;
        om_waddr    = clr_cnt_r;
        om_wdata    = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          req_nxt = in_ch.data;
          if (in_ch.data.mode == MODE_LOAD || in_ch.data.mode == MODE_INIT) begin
            rd_cnt_nxt = '0;
            hit_nxt    = 1'b0;
            vic_nxt    = 1'b0;
            state_nxt  = ST_SCAN;
          end else begin
            sel_ok_nxt = in_sel_x < SLOTS_X;
            sm_re      = in_sel_x < SLOTS_X;
            sm_raddr   = in_sel_x[SW-1:0];
            state_nxt  = ST_RMW;
          end
        end
      end
      ST_SCAN: begin
        // walk tags upward and the order list from its tail
        if (rd_cnt_r < RD_END) begin
          sm_re       = 1'b1;
          sm_raddr    = rd_cnt_r[SW-1:0];
          om_re       = 1'b1;
          om_raddr    = LAST - rd_cnt_r[SW-1:0];
          rd_cnt_nxt  = rd_cnt_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_cnt_r[SW-1:0];
        end
        if (chk_vld_r) begin
          if (!hit_r && req_r.page_tag != EMPTY_TAG && sm_rdata_r.tag == req_r.page_tag) begin
            hit_nxt       = 1'b1;
            hit_slot_nxt  = chk_idx_r;
            hit_owner_nxt = sm_rdata_r.owner;
            hit_kind_nxt  = sm_rdata_r.kind;
          end
          if (!vic_r && !lock_r[om_rdata_r]) begin
            vic_nxt      = 1'b1;
            vic_slot_nxt = om_rdata_r;
          end
          if (chk_idx_r == LAST) begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        mtf_rd_nxt = '0;
        if (hit_r) begin
          res_status_nxt = STAT_HIT;
          res_idx_nxt    = hit_x[SEL_W-1:0];
          res_owner_nxt  = hit_owner_r;
          res_kind_nxt   = hit_kind_r;
          res_lock_nxt   = lock_r[hit_slot_r];
          mtf_slot_nxt   = hit_slot_r;
          carry_nxt      = hit_slot_r;
          state_nxt      = ST_MTF;
        end else if (vic_r) begin
          sm_we          = 1'b1;
          sm_waddr       = vic_slot_r;
          sm_wdata       = '{tag: req_r.page_tag, owner: req_r.owner_page,
                             kind: is_init ? KIND_ERASE : KIND_NONE};
          lk_we          = 1'b1;
          lk_idx         = vic_slot_r;
          lk_val         = is_init;
          res_status_nxt = STAT_MISS;
          res_idx_nxt    = vic_x[SEL_W-1:0];
          res_owner_nxt  = req_r.owner_page;
          res_kind_nxt   = is_init ? KIND_ERASE : KIND_NONE;
          res_lock_nxt   = is_init;
          mtf_slot_nxt   = vic_slot_r;
          carry_nxt      = vic_slot_r;
          state_nxt      = is_init ? ST_RESP : ST_MTF;
        end else begin
          res_status_nxt = STAT_FULL;
          res_idx_nxt    = '0;
          res_owner_nxt  = '0;
          res_kind_nxt   = KIND_NONE;
          res_lock_nxt   = 1'b0;
          state_nxt      = ST_RESP;
        end
      end
      ST_MTF: begin
        // shift entries down one place until the moved slot is passed
        if (mtf_rd_r < RD_END) begin
          om_re      = 1'b1;
          om_raddr   = mtf_rd_r[SW-1:0];
          mtf_rd_nxt = mtf_rd_r + 1'b1;
          mtf_dv_nxt = 1'b1;
          mtf_wp_nxt = mtf_rd_r[SW-1:0];
        end
        if (mtf_dv_r) begin
          om_we     = 1'b1;
          om_waddr  = mtf_wp_r;
          om_wdata  = carry_r;
          carry_nxt = om_rdata_r;
          if (om_rdata_r == mtf_slot_r) begin
            mtf_dv_nxt = 1'b0;
            state_nxt  = ST_RESP;
          end
        end
      end
      ST_RMW: begin
        case (req_r.mode)
          MODE_LOCK: begin
            rmw_lock = 1'b1;
            rmw_wr   = 1'b1;
            if (req_r.kind_req == KIND_PROG) begin
              if (sm_rdata_r.kind == KIND_NONE) begin
                rmw_kind = KIND_PROG;
              end
            end else if (req_r.kind_req != KIND_NONE) begin
              rmw_kind = req_r.kind_req;
            end
          end
          MODE_UNLOCK: begin
            rmw_lock = 1'b0;
            rmw_kind = KIND_NONE;
            rmw_wr   = 1'b1;
          end
          MODE_INVAL: begin
            rmw_ent.tag = EMPTY_TAG;
            rmw_lock    = 1'b0;
            rmw_wr      = 1'b1;
          end
          default: begin
            rmw_wr = 1'b0;
          end
        endcase
        rmw_ent.kind   = rmw_kind;
        res_status_nxt = STAT_DONE;
        res_idx_nxt    = req_r.slot_sel;
        if (sel_ok_r) begin
          sm_we         = rmw_wr;
          sm_waddr      = req_sel_a;
          sm_wdata      = rmw_ent;
          lk_we         = rmw_wr;
          lk_idx        = req_sel_a;
          lk_val        = rmw_lock;
          res_owner_nxt = sm_rdata_r.owner;
          res_kind_nxt  = rmw_kind;
          res_lock_nxt  = rmw_lock;
        end else begin
          res_owner_nxt = '0;
          res_kind_nxt  = KIND_NONE;
          res_lock_nxt  = 1'b0;
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: res_status_r, slot_index: res_idx_r,
                            slot_owner: res_owner_r, slot_kind: res_kind_r,
                            slot_locked: res_lock_r, has_free: has_free};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (lk_we) begin
      lock_nxt[lk_idx] = lk_val;
      if (lock_r[lk_idx] && !lk_val) begin
        free_cnt_nxt = free_cnt_r + 1'b1;
      end else if (!lock_r[lk_idx] && lk_val) begin
        free_cnt_nxt = free_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_cnt_r     <= '0;
      free_needed_r <= FREE_NEEDED_RST;
      rd_cnt_r      <= '0;
      chk_vld_r     <= 1'b0;
      hit_r         <= 1'b0;
      vic_r         <= 1'b0;
      mtf_rd_r      <= '0;
      mtf_dv_r      <= 1'b0;
      lock_r        <= '0;
      free_cnt_r    <= CW'(SLOTS);
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      free_needed_r <= free_needed_nxt;
      rd_cnt_r      <= rd_cnt_nxt;
      chk_vld_r     <= chk_vld_nxt;
      hit_r         <= hit_nxt;
      vic_r         <= vic_nxt;
      mtf_rd_r      <= mtf_rd_nxt;
      mtf_dv_r      <= mtf_dv_nxt;
      lock_r        <= lock_nxt;
      free_cnt_r    <= free_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    sel_ok_r     <= sel_ok_nxt;
    chk_idx_r    <= chk_idx_nxt;
    hit_slot_r   <= hit_slot_nxt;
    hit_owner_r  <= hit_owner_nxt;
    hit_kind_r   <= hit_kind_nxt;
    vic_slot_r   <= vic_slot_nxt;
    mtf_slot_r   <= mtf_slot_nxt;
    carry_r      <= carry_nxt;
    mtf_wp_r     <= mtf_wp_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_owner_r  <= res_owner_nxt;
    res_kind_r   <= res_kind_nxt;
    res_lock_r   <= res_lock_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/lpbd_checker.sv =====
// Checker: port-level assertions of the directory, bound to the top level.
`default_nettype none

module lpbd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lpbd_pkg::out_word_t out_data
);
  import lpbd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_FULL |->
      out_data.slot_index == '0 && out_data.slot_owner == '0 &&
      out_data.slot_kind == KIND_NONE && !out_data.slot_locked)
    else $error("no-free result carries slot data");

  a_miss_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_MISS |->
      (out_data.slot_kind == KIND_NONE && !out_data.slot_locked) ||
      (out_data.slot_kind == KIND_ERASE && out_data.slot_locked))
    else $error("filled slot has inconsistent lock and kind");

endmodule

bind lru_page_buffer_directory lpbd_checker u_lpbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire

// ===== bench/lru_page_buffer_directory_test.sv =====
// Testbench: self-checking bench for the LRU page-buffer directory with slot locks.
`default_nettype none

module lru_page_buffer_directory_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lpbd_pkg::*;

  localparam int NSLOT = 16;
  localparam int HALF_PHASE_ITEMS = 135;
  localparam int SETTLE_CYCLES = 2 * NSLOT + 8;

  class lru_slot_tracker;
    logic [TAG_W-1:0]  tags [NSLOT];
    logic [TAG_W-1:0]  owners [NSLOT];
    logic              locked [NSLOT];
    logic [1:0]        kinds [NSLOT];
    logic [SEL_W-1:0]  order [NSLOT];
    logic [FREE_W-1:0] free_needed;
    out_word_t         awaited_results [$];
    int                errors;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        tags[i] = EMPTY_TAG;
        owners[i] = EMPTY_TAG;
        locked[i] = 1'b0;
        kinds[i] = KIND_NONE;
        order[i] = SEL_W'(i);
      end
      free_needed = FREE_NEEDED_RST;
      errors = 0;
    endfunction

    function void move_to_front(int slot);
      int p;
      p = 0;
      while (p < NSLOT && order[p] != SEL_W'(slot)) p++;
      if (p < NSLOT) begin
        for (int q = p; q > 0; q--) order[q] = order[q-1];
        order[0] = SEL_W'(slot);
      end
    endfunction

    function void note_request(in_word_t w);
      out_word_t r;
      int hit, victim, idx, unlocked;
      bit slot_ok;
      r = '0;
      r.status = STAT_DONE;
      idx = w.slot_sel;
      slot_ok = 1'b1;
      if (w.mode == MODE_LOAD || w.mode == MODE_INIT) begin
        hit = -1;
        if (w.page_tag != EMPTY_TAG)
          for (int i = NSLOT - 1; i >= 0; i--)
            if (tags[i] == w.page_tag) hit = i;
        if (hit >= 0) begin
          move_to_front(hit);
          r.status = STAT_HIT;
          idx = hit;
        end else begin
          victim = -1;
          for (int p = 0; p < NSLOT; p++)
            if (!locked[order[p]]) victim = order[p];
          if (victim < 0) begin
            r.status = STAT_FULL;
            idx = 0;
            slot_ok = 1'b0;
          end else begin
            r.status = STAT_MISS;
            idx = victim;
            tags[idx] = w.page_tag;
            owners[idx] = w.owner_page;
            if (w.mode == MODE_LOAD) begin
              locked[idx] = 1'b0;
              kinds[idx] = KIND_NONE;
              move_to_front(idx);
            end else begin
              locked[idx] = 1'b1;
              kinds[idx] = KIND_ERASE;
            end
          end
        end
      end else if (w.mode == MODE_LOCK) begin
        locked[idx] = 1'b1;
        if (w.kind_req == KIND_PROG) begin
          if (kinds[idx] == KIND_NONE) kinds[idx] = KIND_PROG;
        end else if (w.kind_req != KIND_NONE) begin
          kinds[idx] = w.kind_req;
        end
      end else if (w.mode == MODE_UNLOCK) begin
        locked[idx] = 1'b0;
        kinds[idx] = KIND_NONE;
      end else if (w.mode == MODE_INVAL) begin
        tags[idx] = EMPTY_TAG;
        locked[idx] = 1'b0;
      end
      r.slot_index = SEL_W'(idx);
      if (slot_ok) begin
        r.slot_owner = owners[idx];
        r.slot_kind = kinds[idx];
        r.slot_locked = locked[idx];
      end
      unlocked = 0;
      for (int i = 0; i < NSLOT; i++) if (!locked[i]) unlocked++;
      r.has_free = (unlocked >= int'(free_needed));
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [TAG_W-1:0] exp_v, logic [TAG_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (awaited_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        errors++;
      end else begin
        exp_w = awaited_results.pop_front();
        compare_field("status", TAG_W'(exp_w.status), TAG_W'(got.status));
        compare_field("slot_index", TAG_W'(exp_w.slot_index), TAG_W'(got.slot_index));
        compare_field("slot_owner", exp_w.slot_owner, got.slot_owner);
        compare_field("slot_kind", TAG_W'(exp_w.slot_kind), TAG_W'(got.slot_kind));
        compare_field("slot_locked", TAG_W'(exp_w.slot_locked), TAG_W'(got.slot_locked));
        compare_field("has_free", TAG_W'(exp_w.has_free), TAG_W'(got.has_free));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   sent_words;

  lru_slot_tracker tracker;

  lpbd_in_if  in_ch ();
  lpbd_out_if out_ch ();
  lpbd_cfg_if cfg_ch ();

  lru_page_buffer_directory #(.SLOTS(NSLOT)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sent_words = 0;
    tracker = new();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) tracker.check_result(out_ch.data);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic in_word_t make_request(logic [2:0] mode, logic [TAG_W-1:0] tag,
                                            logic [TAG_W-1:0] owner, int sel,
                                            logic [1:0] kind);
    in_word_t w;
    w.mode = mode;
    w.page_tag = tag;
    w.owner_page = owner;
    w.slot_sel = SEL_W'(sel);
    w.kind_req = kind;
    return w;
  endfunction

  function automatic in_word_t random_request();
    in_word_t w;
    int pick;
    w = '0;
    pick = $urandom_range(99);
    if (pick < 35)      w.mode = MODE_LOAD;
    else if (pick < 50) w.mode = MODE_INIT;
    else if (pick < 65) w.mode = MODE_LOCK;
    else if (pick < 85) w.mode = MODE_UNLOCK;
    else if (pick < 95) w.mode = MODE_INVAL;
    else                w.mode = MODE_INVAL + 3'($urandom_range(1, 3));
    pick = $urandom_range(99);
    if (pick < 75)      w.page_tag = TAG_W'($urandom_range(0, 23));
    else if (pick < 80) w.page_tag = EMPTY_TAG;
    else                w.page_tag = TAG_W'($urandom_range(0, 65535));
    w.owner_page = TAG_W'($urandom_range(0, 65535));
    w.slot_sel = SEL_W'($urandom_range(0, NSLOT - 1));
    w.kind_req = 2'($urandom_range(0, 3));
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_request(w);
    sent_words++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (tracker.awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_free_needed(cfg_word_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    tracker.free_needed = value;
  endtask

  task automatic lock_every_slot();
    for (int s = 0; s < NSLOT; s++)
      send_word(make_request(MODE_LOCK, '0, '0, s, 2'($urandom_range(0, 3))));
    repeat ($urandom_range(1, 3))
      send_word(make_request(3'($urandom_range(MODE_LOAD, MODE_INIT)),
                             TAG_W'($urandom_range(100, 65534)),
                             TAG_W'($urandom_range(0, 65535)), 0, KIND_NONE));
  endtask

  task automatic run_random(int count);
    int stop_at;
    int pick;
    stop_at = sent_words + count;
    while (sent_words < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        lock_every_slot();
      end else if (pick < 8) begin
        for (int s = 0; s < NSLOT; s++)
          send_word(make_request(MODE_UNLOCK, '0, '0, s, KIND_NONE));
      end else begin
        send_word(random_request());
      end
    end
  endtask

  task automatic run_directed();
    send_word(make_request(MODE_LOAD, EMPTY_TAG, 16'h1234, 0, KIND_NONE));
    send_word(make_request(MODE_LOAD, 16'h0000, 16'hffff, 0, KIND_NONE));
    send_word(make_request(MODE_LOAD, 16'h0000, 16'h0001, 0, KIND_NONE));
    send_word(make_request(MODE_LOAD, 16'hfffe, 16'h8001, 0, KIND_NONE));
    send_word(make_request(MODE_INIT, 16'h0000, 16'h0002, 0, KIND_NONE));
    send_word(make_request(MODE_INIT, 16'h5555, 16'haaaa, 0, KIND_NONE));
    send_word(make_request(MODE_INIT, 16'h5555, 16'h0003, 0, KIND_NONE));
    send_word(make_request(MODE_LOCK, '0, '0, 3, KIND_PROG));
    send_word(make_request(MODE_LOCK, '0, '0, 3, KIND_ERASE));
    send_word(make_request(MODE_LOCK, '0, '0, 3, KIND_PROG));
    send_word(make_request(MODE_LOCK, '0, '0, 4, KIND_RELOC));
    send_word(make_request(MODE_LOCK, '0, '0, 5, KIND_NONE));
    send_word(make_request(MODE_LOCK, '0, '0, NSLOT - 1, KIND_RELOC));
    send_word(make_request(MODE_UNLOCK, '0, '0, 3, KIND_NONE));
    send_word(make_request(MODE_INVAL, '0, '0, NSLOT - 1, KIND_NONE));
    send_word(make_request(MODE_INVAL, '0, '0, NSLOT - 2, KIND_NONE));
    send_word(make_request(MODE_INVAL + 3'd1, 16'hffff, 16'hffff, NSLOT - 1, KIND_RELOC));
    send_word(make_request(MODE_INVAL + 3'd2, '0, '0, 0, KIND_PROG));
    send_word(make_request(MODE_INVAL + 3'd3, '0, '0, 9, KIND_ERASE));
    send_word(make_request(MODE_LOAD, 16'h0000, 16'h0004, 0, KIND_NONE));
    send_word(make_request(MODE_UNLOCK, '0, '0, 4, KIND_NONE));
    send_word(make_request(MODE_UNLOCK, '0, '0, 5, KIND_NONE));
  endtask

  task automatic run_phase(int snd_pct, int rcv_pct, cfg_word_t first_cfg,
                           cfg_word_t second_cfg);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    wait_drained();
    write_free_needed(first_cfg);
    run_random(HALF_PHASE_ITEMS);
    wait_drained();
    write_free_needed(second_cfg);
    run_random(HALF_PHASE_ITEMS);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 11;
    recv_idle_pct = 81;
    run_directed();
    wait_drained();
    lock_every_slot();
    run_phase(11, 81, 5'd0, 5'd16);
    run_phase(81, 11, 5'd31, cfg_word_t'($urandom_range(1, NSLOT)));
    run_phase(0, 0, 5'd1, 5'd17);
    wait_drained();
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/lpbd_pkg.sv
sv/lpbd_if.sv
sv/lru_page_buffer_directory.sv
sv/lpbd_checker.sv
bench/lru_page_buffer_directory_test.sv
